@@ hdl/hnhi_pkg.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// hnhi_pkg
// Shared widths, codes and helpers for the Hamming nearest hash index.
// ----------------------------------------------------------------------------
package hnhi_pkg;

  localparam int ENTRIES   = 64;
  localparam int IDX_W     = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int CNT_W     = $clog2(ENTRIES + 1);
  localparam int HASH_W    = 64;
  localparam int ID_W      = 64;
  localparam int DIST_W    = 7;
  localparam int OCC_W     = 7;
  localparam int LIMIT_W   = 7;
  localparam int MAX_ITEMS = 64;
  localparam int OCC_MAX   = 127;

  localparam logic [DIST_W-1:0]  DIST_NONE  = DIST_W'(65);
  localparam logic [LIMIT_W-1:0] LIMIT_CAP  = LIMIT_W'(MAX_ITEMS);
  localparam logic [IDX_W-1:0]   LAST_IDX   = IDX_W'(ENTRIES - 1);

  typedef enum logic [1:0] {
    OP_INSERT  = 2'd0,
    OP_REMOVE  = 2'd1,
    OP_NEAREST = 2'd2,
    OP_RANGE   = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_NONE  = 2'd2,
    ST_EMPTY = 2'd3
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE  = 3'b001,
    S_SCAN  = 3'b010,
    S_DRAIN = 3'b100
  } state_t;

  // Per-byte counts, then a sum of the eight byte counts.
  function automatic logic [DIST_W-1:0] popcount64(input logic [HASH_W-1:0] v);
    logic [3:0]        byte_cnt [8];
    logic [DIST_W-1:0] sum;
    sum = '0;
    for (int b = 0; b < 8; b++) begin
      byte_cnt[b] = '0;
      for (int k = 0; k < 8; k++) begin
        byte_cnt[b] = byte_cnt[b] + 4'(v[8*b+k]);
      end
    end
    for (int b = 0; b < 8; b++) begin
      sum = sum + DIST_W'(byte_cnt[b]);
    end
    return sum;
  endfunction

  function automatic logic [OCC_W-1:0] occ_sat(input logic [CNT_W-1:0] c);
    if (32'(c) > 32'(OCC_MAX)) begin
      return OCC_W'(OCC_MAX);
    end
    return OCC_W'(c);
  endfunction

endpackage
`default_nettype wire

@@ hdl/hamming_nearest_hash_index.sv @@
// Insert, remove, nearest and range scan the slot memory one slot a cycle; one
// operation runs at a time, the scan rate set by the single read port of the slot
// memories. A range query gives its matches in slot order.
// Reset clears the valid bits and the count at once; no clearing pass is needed.
// Results are strobed for one cycle; the receiver cannot stall.
`default_nettype none
// ----------------------------------------------------------------------------
// hamming_nearest_hash_index
// Linear-scan Hamming nearest-neighbour table with insert, remove, nearest
// and range operations over 64-bit hashes and ids.
// ----------------------------------------------------------------------------
module hamming_nearest_hash_index (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          start,
  output      logic                          busy,
  input  wire logic [1:0]                    op,
  input  wire logic [hnhi_pkg::HASH_W-1:0]   key_hash,
  input  wire logic [hnhi_pkg::ID_W-1:0]     entry_id,
  input  wire logic [hnhi_pkg::DIST_W-1:0]   max_distance,
  input  wire logic [hnhi_pkg::LIMIT_W-1:0]  result_limit,
  output      logic                          strobe,
  output      logic [1:0]                    status,
  output      logic [hnhi_pkg::ID_W-1:0]     found_id,
  output      logic [hnhi_pkg::HASH_W-1:0]   found_hash,
  output      logic [hnhi_pkg::DIST_W-1:0]   distance,
  output      logic [hnhi_pkg::OCC_W-1:0]    occupancy,
  output      logic                          last
);

  hnhi_pkg::state_t state;

  logic [hnhi_pkg::HASH_W-1:0]  slot_hash [hnhi_pkg::ENTRIES];
  logic [hnhi_pkg::ID_W-1:0]    slot_id   [hnhi_pkg::ENTRIES];
  logic [hnhi_pkg::HASH_W-1:0]  rd_hash;
  logic [hnhi_pkg::ID_W-1:0]    rd_id;

  logic [hnhi_pkg::ENTRIES-1:0] valid;
  logic [hnhi_pkg::CNT_W-1:0]   count;

  hnhi_pkg::op_t                q_op;
  logic [hnhi_pkg::HASH_W-1:0]  q_key;
  logic [hnhi_pkg::ID_W-1:0]    q_id;
  logic [hnhi_pkg::DIST_W-1:0]  q_maxd;
  logic [hnhi_pkg::LIMIT_W-1:0] q_limit;

  logic [hnhi_pkg::IDX_W-1:0]   scan_idx;
  logic                         issue_on;
  logic                         p1_act;
  logic [hnhi_pkg::IDX_W-1:0]   p1_idx;
  logic                         p2_act;
  logic [hnhi_pkg::IDX_W-1:0]   p2_idx;
  logic [hnhi_pkg::DIST_W-1:0]  p2_dist;
  logic [hnhi_pkg::ID_W-1:0]    p2_id;
  logic [hnhi_pkg::HASH_W-1:0]  p2_hash;

  logic [hnhi_pkg::DIST_W-1:0]  min_hd;
  logic [hnhi_pkg::ID_W-1:0]    best_id;
  logic [hnhi_pkg::LIMIT_W-1:0] found;
  logic                         pend_vld;
  logic [hnhi_pkg::ID_W-1:0]    pend_id;
  logic [hnhi_pkg::HASH_W-1:0]  pend_hash;
  logic [hnhi_pkg::DIST_W-1:0]  pend_dist;

  logic                         accept;
  logic                         mem_we;
  logic                         p2_live;
  logic                         p2_hit;

  assign busy    = (state != hnhi_pkg::S_IDLE);
  assign accept  = start && !busy;
  assign mem_we  = (state == hnhi_pkg::S_SCAN) && (q_op == hnhi_pkg::OP_INSERT) &&
                   !valid[scan_idx];
  assign p2_live = p2_act && valid[p2_idx];
  assign p2_hit  = p2_live && (p2_dist <= q_maxd) && (found < q_limit);

  always_ff @(posedge clk) begin
    if (mem_we) begin
      slot_hash[scan_idx] <= q_key;
      slot_id[scan_idx]   <= q_id;
    end
    rd_hash <= slot_hash[scan_idx];
    rd_id   <= slot_id[scan_idx];
  end

  always_ff @(posedge clk) begin
    p2_idx  <= p1_idx;
    p2_dist <= hnhi_pkg::popcount64(rd_hash ^ q_key);
    p2_id   <= rd_id;
    p2_hash <= rd_hash;
    p1_idx  <= scan_idx;
    if (accept) begin
      q_op    <= hnhi_pkg::op_t'(op);
      q_key   <= key_hash;
      q_id    <= entry_id;
      q_maxd  <= max_distance;
      q_limit <= (result_limit > hnhi_pkg::LIMIT_CAP) ? hnhi_pkg::LIMIT_CAP : result_limit;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= hnhi_pkg::S_IDLE;
      valid     <= '0;
      count     <= '0;
      strobe    <= 1'b0;
      scan_idx  <= '0;
      issue_on  <= 1'b0;
      p1_act    <= 1'b0;
      p2_act    <= 1'b0;
      min_hd    <= hnhi_pkg::DIST_NONE;
      found     <= '0;
      pend_vld  <= 1'b0;
    end else begin
      strobe <= 1'b0;
      unique case (state)
        hnhi_pkg::S_IDLE: begin
          if (start) begin
            state     <= hnhi_pkg::S_SCAN;
            scan_idx  <= '0;
            issue_on  <= 1'b1;
            p1_act    <= 1'b0;
            p2_act    <= 1'b0;
            min_hd    <= hnhi_pkg::DIST_NONE;
            found     <= '0;
            pend_vld  <= 1'b0;
          end
        end
        hnhi_pkg::S_SCAN: begin
          if (q_op == hnhi_pkg::OP_INSERT) begin
            if (!valid[scan_idx]) begin
              valid[scan_idx] <= 1'b1;
              count      <= count + hnhi_pkg::CNT_W'(1);
              strobe     <= 1'b1;
              status     <= hnhi_pkg::ST_OK;
              found_id   <= '0;
              found_hash <= '0;
              distance   <= '0;
              occupancy  <= hnhi_pkg::occ_sat(count + hnhi_pkg::CNT_W'(1));
              last       <= 1'b1;
              state      <= hnhi_pkg::S_IDLE;
            end else if (scan_idx == hnhi_pkg::LAST_IDX) begin
              strobe     <= 1'b1;
              status     <= hnhi_pkg::ST_FULL;
              found_id   <= '0;
              found_hash <= '0;
              distance   <= '0;
              occupancy  <= hnhi_pkg::occ_sat(count);
              last       <= 1'b1;
              state      <= hnhi_pkg::S_IDLE;
            end else begin
              scan_idx <= scan_idx + hnhi_pkg::IDX_W'(1);
            end
          end else begin
            // advance the read pipeline
            p1_act <= issue_on;
            p2_act <= p1_act;
            if (issue_on) begin
              if (scan_idx == hnhi_pkg::LAST_IDX) begin
                issue_on <= 1'b0;
              end else begin
                scan_idx <= scan_idx + hnhi_pkg::IDX_W'(1);
              end
            end
            if (p2_act) begin
              unique case (q_op)
                hnhi_pkg::OP_REMOVE: begin
                  if (p2_live && (p2_id == q_id)) begin
                    valid[p2_idx] <= 1'b0;
                    count      <= count - hnhi_pkg::CNT_W'(1);
                    strobe     <= 1'b1;
                    status     <= hnhi_pkg::ST_OK;
                    found_id   <= '0;
                    found_hash <= '0;
                    distance   <= '0;
                    occupancy  <= hnhi_pkg::occ_sat(count - hnhi_pkg::CNT_W'(1));
                    last       <= 1'b1;
                    state      <= hnhi_pkg::S_IDLE;
                    issue_on   <= 1'b0;
                    p1_act     <= 1'b0;
                    p2_act     <= 1'b0;
                  end else if (p2_idx == hnhi_pkg::LAST_IDX) begin
                    state <= hnhi_pkg::S_DRAIN;
                  end
                end
                hnhi_pkg::OP_NEAREST: begin
                  if (p2_live && (p2_dist < min_hd)) begin
                    min_hd  <= p2_dist;
                    best_id <= p2_id;
                  end
                  if (p2_idx == hnhi_pkg::LAST_IDX) begin
                    state <= hnhi_pkg::S_DRAIN;
                  end
                end
                default: begin
                  if (p2_hit) begin
                    found     <= found + hnhi_pkg::LIMIT_W'(1);
                    pend_vld  <= 1'b1;
                    pend_id   <= p2_id;
                    pend_hash <= p2_hash;
                    pend_dist <= p2_dist;
                    if (pend_vld) begin
                      strobe     <= 1'b1;
                      status     <= hnhi_pkg::ST_OK;
                      found_id   <= pend_id;
                      found_hash <= pend_hash;
                      distance   <= pend_dist;
                      occupancy  <= hnhi_pkg::occ_sat(count);
                      last       <= 1'b0;
                    end
                  end
                  if ((p2_hit && (found + hnhi_pkg::LIMIT_W'(1) == q_limit)) ||
                      (p2_idx == hnhi_pkg::LAST_IDX)) begin
                    state    <= hnhi_pkg::S_DRAIN;
                    issue_on <= 1'b0;
                    p1_act   <= 1'b0;
                    p2_act   <= 1'b0;
                  end
                end
              endcase
            end
          end
        end
        hnhi_pkg::S_DRAIN: begin
          strobe    <= 1'b1;
          occupancy <= hnhi_pkg::occ_sat(count);
          last      <= 1'b1;
          state     <= hnhi_pkg::S_IDLE;
          issue_on  <= 1'b0;
          p1_act    <= 1'b0;
          p2_act    <= 1'b0;
          found_id   <= '0;
          found_hash <= '0;
          distance   <= '0;
          unique case (q_op)
            hnhi_pkg::OP_NEAREST: begin
              if (min_hd == hnhi_pkg::DIST_NONE) begin
                status <= hnhi_pkg::ST_EMPTY;
              end else begin
                status   <= hnhi_pkg::ST_OK;
                found_id <= best_id;
                distance <= min_hd;
              end
            end
            hnhi_pkg::OP_RANGE: begin
              if (pend_vld) begin
                status     <= hnhi_pkg::ST_OK;
                found_id   <= pend_id;
                found_hash <= pend_hash;
                distance   <= pend_dist;
              end else begin
                status <= hnhi_pkg::ST_NONE;
              end
            end
            default: begin
              status <= hnhi_pkg::ST_NONE;
            end
          endcase
        end
        default: begin
          state <= hnhi_pkg::S_IDLE;
        end
      endcase
    end
  end

`ifndef SYNTHESIS
  a_count_matches_valid: assert property (@(posedge clk) disable iff (rst)
    $countones(valid) == 32'(count))
    else $error("valid count out of step with valid bits");

  a_strobe_from_busy: assert property (@(posedge clk) disable iff (rst)
    strobe |-> $past(busy))
    else $error("result beat without an operation in progress");

  a_not_last_is_range_ok: assert property (@(posedge clk) disable iff (rst)
    (strobe && !last) |-> (status == hnhi_pkg::ST_OK && q_op == hnhi_pkg::OP_RANGE))
    else $error("intermediate beat outside a range query");

  a_pipe_only_in_scan: assert property (@(posedge clk) disable iff (rst)
    (p1_act || p2_act) |-> (state == hnhi_pkg::S_SCAN))
    else $error("read pipeline active outside the scan");

  a_range_within_limit: assert property (@(posedge clk) disable iff (rst)
    (strobe && q_op == hnhi_pkg::OP_RANGE) |-> (found <= q_limit))
    else $error("range query returned more beats than its limit");
`endif

endmodule
`default_nettype wire
